@@ hw/rtl/mpws_pkg.sv @@
// ============================================================================
// mpws_pkg
// Shared types and constants for the periodic window scheduler.
// ============================================================================
package mpws_pkg;

    localparam int PERIOD_W    = 16;  // period and countdown width in ticks
    localparam int ID_W        = 3;   // window_id field width
    localparam int STATUS_W    = 2;
    localparam int MAX_RESULTS = 8;
    localparam int EMIT_W      = 3;   // counts results of one tick
    localparam int M_DATA_W    = 8;   // id and status padded to a byte

    localparam logic REQ_CREATE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_READY = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EXISTS  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_DUP_RD,
        S_DUP_CHK,
        S_ADD,
        S_TK_RD,
        S_TK_CHK,
        S_SEL_RD,
        S_SEL_CHK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                done;
        logic [PERIOD_W-1:0] quotient;
        logic                rem_zero;
    } div_result_t;

endpackage

@@ hw/rtl/mpws_divider.sv @@
// ============================================================================
// mpws_divider
// Division by a constant through reciprocal multiplication, then a registered remainder check.
// ============================================================================
module mpws_divider
    import mpws_pkg::*;
#(
    parameter int DIVISOR = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [PERIOD_W-1:0] dividend,
    output div_result_t         result
);

    // The reciprocal is rounded up and scaled by 2^(PERIOD_W + ceil(log2 DIVISOR)),
    // which makes the truncated product exact for every dividend of PERIOD_W bits.
    localparam int     SHIFT_EXTRA = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
    localparam int     SHIFT       = PERIOD_W + SHIFT_EXTRA;
    localparam int     RECIP_W     = PERIOD_W + 1;
    localparam longint RECIP_VAL   =
        ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam int     DIV_W       = $clog2(DIVISOR + 1);
    localparam logic [DIV_W-1:0] DIV_CONST = DIV_W'(DIVISOR);
    localparam int     PROD_W      = PERIOD_W + RECIP_W;
    localparam int     BACK_W      = PERIOD_W + DIV_W;

    logic                mul_reg, mul_next;
    logic                chk_reg, chk_next;
    logic                done_reg, done_next;
    logic [PERIOD_W-1:0] x_reg, x_next;
    logic [PERIOD_W-1:0] q_reg, q_next;
    logic                rz_reg, rz_next;
    logic [PROD_W-1:0]   product;
    logic [BACK_W-1:0]   back;

    always_comb begin
        product   = PROD_W'(x_reg) * PROD_W'(RECIP);
        back      = BACK_W'(q_reg) * BACK_W'(DIV_CONST);
        mul_next  = start;
        chk_next  = mul_reg;
        done_next = chk_reg;
        x_next    = start ? dividend : x_reg;
        q_next    = mul_reg ? PERIOD_W'(product >> SHIFT) : q_reg;
        // The remainder is zero exactly when quotient times divisor gives the dividend back.
        rz_next   = chk_reg ? (back == BACK_W'(x_reg)) : rz_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg  <= 1'b0;
            chk_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            mul_reg  <= mul_next;
            chk_reg  <= chk_next;
            done_reg <= done_next;
        end
        x_reg  <= x_next;
        q_reg  <= q_next;
        rz_reg <= rz_next;
    end

    assign result.done     = done_reg;
    assign result.quotient = q_reg;
    assign result.rem_zero = rz_reg;

endmodule

@@ hw/rtl/mpws_table.sv @@
// ============================================================================
// mpws_table
// Window period and countdown memories, one read port with registered data.
// ============================================================================
module mpws_table
    import mpws_pkg::*;
#(
    parameter int SLOTS = 8,
    parameter int IDX_W = 3
) (
    input  logic                aclk,
    input  logic [IDX_W-1:0]    rd_idx,
    output logic [PERIOD_W-1:0] rd_period,
    output logic [PERIOD_W-1:0] rd_countdown,
    input  logic                wr_period_en,
    input  logic                wr_cd_en,
    input  logic [IDX_W-1:0]    wr_idx,
    input  logic [PERIOD_W-1:0] wr_period,
    input  logic [PERIOD_W-1:0] wr_cd
);

    logic [PERIOD_W-1:0] period_mem [SLOTS];
    logic [PERIOD_W-1:0] cd_mem     [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_period_en) begin
            period_mem[wr_idx] <= wr_period;
        end
        if (wr_cd_en) begin
            cd_mem[wr_idx] <= wr_cd;
        end
        rd_period    <= period_mem[rd_idx];
        rd_countdown <= cd_mem[rd_idx];
    end

endmodule

@@ hw/rtl/multi_period_window_scheduler.sv @@
// ============================================================================
// multi_period_window_scheduler
// Table of periodic windows driven by create and tick transactions.
// ============================================================================
// Input channel s_*: s_tuser selects the request (create or tick), s_tdata
// carries the period in milliseconds for a create. Result channel m_*: m_tuser
// carries the result kind, m_tdata the window id and status, and m_tlast
// marks the final result caused by one input transaction.
// A create is accepted, passes the reciprocal-multiply divider, scans the
// windows in use for a duplicate period, and is stored, then the reply is
// offered; a rejected create skips what follows the rejection. A tick makes
// a countdown pass over the windows in use, then one pass over the windows
// in use for each ready result to find the smallest ready period, and each
// result is offered on m_*; a tick that readies nothing gives no result.
// The table's single read port sets the per-window cost of each pass.
// Only one transaction is in work at a time: s_tready is high only when the
// block is idle, and a result is held on m_* until the receiver takes it,
// stalling the sequencer meanwhile. Reset empties the table (window count
// zero) and returns the sequencer to idle; the memories need no clearing.
// ============================================================================
module multi_period_window_scheduler
    import mpws_pkg::*;
#(
    parameter int WINDOW_SLOTS   = 8,
    parameter int BASE_PERIOD_MS = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [PERIOD_W-1:0] s_tdata,   // [15:0] requested period in ms
    input  logic                s_tuser,   // [0] req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [2:0] window_id, [4:3] status,
                                           // [7:5] zero
    output logic                m_tuser,   // [0] result_kind
    output logic                m_tlast
);

    localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(WINDOW_SLOTS);
    localparam logic [EMIT_W-1:0] EMIT_LAST = EMIT_W'(MAX_RESULTS - 1);

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [WINDOW_SLOTS-1:0] ready_reg, ready_next;
    logic [CNT_W-1:0]        ready_cnt_reg, ready_cnt_next;
    logic [EMIT_W-1:0]       emit_reg, emit_next;
    logic                    found_reg, found_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [PERIOD_W-1:0]     best_period_reg, best_period_next;
    logic                    out_kind_reg, out_kind_next;
    logic [ID_W-1:0]         out_id_reg, out_id_next;
    status_t                 out_status_reg, out_status_next;
    logic                    out_last_reg, out_last_next;

    div_result_t             div_res;
    logic                    div_start;
    logic [PERIOD_W-1:0]     rd_period, rd_cd;
    logic                    wr_period_en, wr_cd_en;
    logic [IDX_W-1:0]        wr_idx;
    logic [PERIOD_W-1:0]     wr_period, wr_cd;

    logic                    in_fire, out_fire;
    logic [IDX_W-1:0]        last_idx;
    logic                    at_last;
    logic                    bad_period;
    logic                    table_full;
    logic [PERIOD_W-1:0]     cd_dec;
    logic                    cd_zero;
    logic                    cand;
    logic [IDX_W-1:0]        pick_idx;

    mpws_divider #(
        .DIVISOR (BASE_PERIOD_MS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_tdata),
        .result   (div_res)
    );

    mpws_table #(
        .SLOTS (WINDOW_SLOTS),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk         (aclk),
        .rd_idx       (idx_reg),
        .rd_period    (rd_period),
        .rd_countdown (rd_cd),
        .wr_period_en (wr_period_en),
        .wr_cd_en     (wr_cd_en),
        .wr_idx       (wr_idx),
        .wr_period    (wr_period),
        .wr_cd        (wr_cd)
    );

    assign in_fire    = s_tvalid && s_tready;
    assign out_fire   = m_tvalid && m_tready;
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign at_last    = (idx_reg == last_idx);
    assign bad_period = (div_res.quotient == '0) || !div_res.rem_zero;
    assign table_full = (count_reg >= SLOTS_CNT);
    assign cd_dec     = rd_cd - PERIOD_W'(1);
    assign cd_zero    = (cd_dec == '0);
    assign cand       = ready_reg[idx_reg] && (!found_reg || (rd_period < best_period_reg));
    assign pick_idx   = cand ? idx_reg : best_idx_reg;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (s_tuser == REQ_CREATE) begin
                        state_next = S_DIV;
                    end else if (count_reg != '0) begin
                        state_next = S_TK_RD;
                    end
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    if (bad_period || table_full) begin
                        state_next = S_OUT;
                    end else if (count_reg == '0) begin
                        state_next = S_ADD;
                    end else begin
                        state_next = S_DUP_RD;
                    end
                end
            end
            S_DUP_RD:  state_next = S_DUP_CHK;
            S_DUP_CHK: begin
                if (rd_period == div_res.quotient) begin
                    state_next = S_OUT;
                end else if (at_last) begin
                    state_next = S_ADD;
                end else begin
                    state_next = S_DUP_RD;
                end
            end
            S_ADD:     state_next = S_OUT;
            S_TK_RD:   state_next = S_TK_CHK;
            S_TK_CHK: begin
                if (at_last) begin
                    state_next = (ready_cnt_next == '0) ? S_IDLE : S_SEL_RD;
                end else begin
                    state_next = S_TK_RD;
                end
            end
            S_SEL_RD:  state_next = S_SEL_CHK;
            S_SEL_CHK: begin
                if (at_last) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_SEL_RD;
                end
            end
            S_OUT: begin
                if (out_fire) begin
                    state_next = out_last_reg ? S_IDLE : S_SEL_RD;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        idx_next         = idx_reg;
        count_next       = count_reg;
        ready_next       = ready_reg;
        ready_cnt_next   = ready_cnt_reg;
        emit_next        = emit_reg;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_period_next = best_period_reg;
        out_kind_next    = out_kind_reg;
        out_id_next      = out_id_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        div_start        = 1'b0;
        wr_period_en     = 1'b0;
        wr_cd_en         = 1'b0;
        wr_idx           = idx_reg;
        wr_period        = div_res.quotient;
        wr_cd            = div_res.quotient;
        s_tready         = 1'b0;
        m_tvalid         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (in_fire) begin
                    idx_next = '0;
                    if (s_tuser == REQ_CREATE) begin
                        div_start = 1'b1;
                    end else begin
                        ready_next     = '0;
                        ready_cnt_next = '0;
                        emit_next      = '0;
                    end
                end
            end
            S_DIV: begin
                out_kind_next = KIND_REPLY;
                out_id_next   = '0;
                out_last_next = 1'b1;
                if (bad_period) begin
                    out_status_next = ST_INVALID;
                end else if (table_full) begin
                    out_status_next = ST_FULL;
                end
            end
            S_DUP_RD: begin
            end
            S_DUP_CHK: begin
                if (rd_period == div_res.quotient) begin
                    out_status_next = ST_EXISTS;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_ADD: begin
                wr_period_en    = 1'b1;
                wr_cd_en        = 1'b1;
                wr_idx          = count_reg[IDX_W-1:0];
                out_id_next     = ID_W'(count_reg[IDX_W-1:0]);
                out_status_next = ST_OK;
                count_next      = count_reg + CNT_W'(1);
            end
            S_TK_RD: begin
            end
            S_TK_CHK: begin
                wr_cd_en = 1'b1;
                wr_cd    = cd_zero ? rd_period : cd_dec;
                if (cd_zero) begin
                    ready_next[idx_reg] = 1'b1;
                    ready_cnt_next      = ready_cnt_reg + CNT_W'(1);
                end
                idx_next   = at_last ? '0 : idx_reg + IDX_W'(1);
                found_next = 1'b0;
            end
            S_SEL_RD: begin
            end
            S_SEL_CHK: begin
                if (cand) begin
                    found_next       = 1'b1;
                    best_idx_next    = idx_reg;
                    best_period_next = rd_period;
                end
                if (at_last) begin
                    out_kind_next        = KIND_READY;
                    out_id_next          = ID_W'(pick_idx);
                    out_status_next      = ST_OK;
                    out_last_next        = (ready_cnt_reg == CNT_W'(1)) ||
                                           (emit_reg == EMIT_LAST);
                    ready_next[pick_idx] = 1'b0;
                    ready_cnt_next       = ready_cnt_reg - CNT_W'(1);
                    emit_next            = emit_reg + EMIT_W'(1);
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_OUT: begin
                m_tvalid = 1'b1;
                if (out_fire) begin
                    idx_next   = '0;
                    found_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ready_reg     <= '0;
            ready_cnt_reg <= '0;
            emit_reg      <= '0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ready_reg     <= ready_next;
            ready_cnt_reg <= ready_cnt_next;
            emit_reg      <= emit_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
        end
        best_idx_reg    <= best_idx_next;
        best_period_reg <= best_period_next;
        out_kind_reg    <= out_kind_next;
        out_id_reg      <= out_id_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tdata = {3'b000, out_status_reg, out_id_reg};
    assign m_tuser = out_kind_reg;
    assign m_tlast = out_last_reg;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result channels active together");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= SLOTS_CNT)
        else $error("window count above slot limit");

    a_ready_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_kind_reg == KIND_READY) |-> (out_status_reg == ST_OK))
        else $error("ready result with nonzero status");

    a_ready_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEL_RD || state_reg == S_SEL_CHK || state_reg == S_OUT)
        |-> (ready_cnt_reg == CNT_W'($countones(ready_reg))))
        else $error("ready count disagrees with ready flags");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && m_tlast) |=> s_tready)
        else $error("block not idle after final result");
`endif

endmodule

@@ test/mpws_checker.sv @@
// ============================================================================
// mpws_checker
// Watches both stream channels of the periodic window scheduler, keeps its
// own copy of the window table, and compares every result transaction with
// the oldest predicted result.
// ============================================================================
module mpws_checker
    import mpws_pkg::*;
#(
    parameter int WINDOW_SLOTS   = 8,
    parameter int BASE_PERIOD_MS = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [PERIOD_W-1:0] s_tdata,   // [15:0] requested period in ms
    input  logic                s_tuser,   // [0] req_type
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // [2:0] window_id, [4:3] status,
                                           // [7:5] zero
    input  logic                m_tuser,   // [0] result_kind
    input  logic                m_tlast,
    output int                  fail_count,
    output int                  pending_results,
    output int                  results_checked,
    output int                  widest_burst
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] id;
        status_t         status;
        logic            last;
    } window_result_t;

    logic [PERIOD_W-1:0] period_ticks [WINDOW_SLOTS];
    logic [PERIOD_W-1:0] ticks_left   [WINDOW_SLOTS];
    int                  windows_used;
    window_result_t      expected_results [$];
    window_result_t      want;
    window_result_t      got;

    task automatic predict_create(input logic [PERIOD_W-1:0] ms);
        logic [PERIOD_W-1:0] ticks;
        window_result_t      r;
        int                  i;
        ticks    = PERIOD_W'(ms / BASE_PERIOD_MS);
        r.kind   = KIND_REPLY;
        r.id     = '0;
        r.last   = 1'b1;
        if (ticks == '0 || (ms % BASE_PERIOD_MS) != 0) begin
            r.status = ST_INVALID;
        end else if (windows_used >= WINDOW_SLOTS) begin
            r.status = ST_FULL;
        end else begin
            r.status = ST_OK;
            for (i = 0; i < windows_used; i++) begin
                if (period_ticks[i] == ticks) begin
                    r.status = ST_EXISTS;
                end
            end
            if (r.status == ST_OK) begin
                period_ticks[windows_used] = ticks;
                ticks_left[windows_used]   = ticks;
                r.id                       = ID_W'(windows_used);
                windows_used++;
            end
        end
        expected_results.push_back(r);
    endtask

    task automatic predict_tick();
        logic           ready [WINDOW_SLOTS];
        int             order [$];
        int             i;
        int             best;
        window_result_t r;
        if (windows_used == 0) begin
            return;
        end
        for (i = 0; i < WINDOW_SLOTS; i++) begin
            ready[i] = 1'b0;
            if (i < windows_used) begin
                ticks_left[i] = ticks_left[i] - 1'b1;
                if (ticks_left[i] == '0) begin
                    ticks_left[i] = period_ticks[i];
                    ready[i]      = 1'b1;
                end
            end
        end
        // Periods are unique, so picking the smallest ready period each round
        // gives a strict ascending order.
        while (order.size() < MAX_RESULTS) begin
            best = -1;
            for (i = 0; i < windows_used; i++) begin
                if (ready[i] && (best < 0 || period_ticks[i] < period_ticks[best])) begin
                    best = i;
                end
            end
            if (best < 0) begin
                break;
            end
            ready[best] = 1'b0;
            order.push_back(best);
        end
        for (i = 0; i < order.size(); i++) begin
            r.kind   = KIND_READY;
            r.id     = ID_W'(order[i]);
            r.status = ST_OK;
            r.last   = (i == order.size() - 1);
            expected_results.push_back(r);
        end
        if (order.size() > widest_burst) begin
            widest_burst = order.size();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            windows_used    = 0;
            fail_count      = 0;
            results_checked = 0;
            widest_burst    = 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                got.kind   = m_tuser;
                got.id     = m_tdata[2:0];
                got.status = status_t'(m_tdata[4:3]);
                got.last   = m_tlast;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display({"%0t: unexpected result, expected none, ",
                                  "got kind=%0d id=%0d status=%0d last=%0d"},
                                 $time, got.kind, got.id, got.status, got.last);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want || m_tdata[7:5] !== '0) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display({"%0t: result mismatch, expected ",
                                      "kind=%0d id=%0d status=%0d last=%0d pad=0"},
                                     $time, want.kind, want.id, want.status,
                                     want.last);
                            $display({"%0t:                  got ",
                                      "kind=%0d id=%0d status=%0d last=%0d pad=%0d"},
                                     $time, got.kind, got.id, got.status,
                                     got.last, m_tdata[7:5]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_CREATE) begin
                    predict_create(s_tdata);
                end else begin
                    predict_tick();
                end
            end
        end
        pending_results = expected_results.size();
    end

endmodule

@@ test/testbench.sv @@
// ============================================================================
// testbench
// Drives create and tick transactions into the periodic window scheduler
// under several idle and stall patterns; the checker predicts and compares.
// ============================================================================
module testbench;
    import mpws_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_SLOTS   = 8;
    localparam int BASE_PERIOD_MS = 10;
    localparam int RANDOM_ITEMS   = 500;
    localparam int PHASE_LEN      = 50;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 200;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [PERIOD_W-1:0] s_tdata  = '0;
    logic                s_tuser  = REQ_CREATE;
    logic                m_tready = 1'b0;
    wire                 s_tready;
    wire                 m_tvalid;
    wire  [M_DATA_W-1:0] m_tdata;
    wire                 m_tuser;
    wire                 m_tlast;

    int fail_count;
    int pending_results;
    int results_checked;
    int widest_burst;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int creates_sent   = 0;
    int idle_cycles    = 0;
    int pick;

    initial begin
        forever #4 aclk = ~aclk;
    end

    multi_period_window_scheduler #(
        .WINDOW_SLOTS   (WINDOW_SLOTS),
        .BASE_PERIOD_MS (BASE_PERIOD_MS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mpws_checker #(
        .WINDOW_SLOTS   (WINDOW_SLOTS),
        .BASE_PERIOD_MS (BASE_PERIOD_MS)
    ) window_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .widest_burst    (widest_burst)
    );

    always @(posedge aclk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Any accepted transaction on either channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic kind, input logic [PERIOD_W-1:0] ms);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= ms;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        items_sent++;
        if (kind == REQ_CREATE) begin
            creates_sent++;
        end
        // Rotate through the idle patterns so each lands on every kind of work.
        case ((items_sent / PHASE_LEN) % 4)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 78;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 78;
            end
            default: begin
                send_idle_pct  = 27;
                recv_stall_pct = 27;
            end
        endcase
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(REQ_TICK, '0);            // empty table gives no result
        send_item(REQ_CREATE, 16'd0);
        send_item(REQ_CREATE, 16'd7);       // below one base period
        send_item(REQ_CREATE, 16'd15);      // not a whole number of base periods
        send_item(REQ_CREATE, 16'hFFFF);
        // Powers of two created back to back all line up after 128 ticks,
        // and the descending order makes the ready order the reverse of slots.
        send_item(REQ_CREATE, 16'd1280);
        send_item(REQ_CREATE, 16'd640);
        send_item(REQ_CREATE, 16'd320);
        send_item(REQ_CREATE, 16'd1280);    // duplicate period
        send_item(REQ_CREATE, 16'd160);
        send_item(REQ_CREATE, 16'd80);
        send_item(REQ_CREATE, 16'd40);
        send_item(REQ_CREATE, 16'd20);
        send_item(REQ_CREATE, 16'd10);
        send_item(REQ_CREATE, 16'd30);      // table full
        send_item(REQ_CREATE, 16'd65530);
        send_item(REQ_CREATE, 16'd5);       // invalid wins over full
        send_item(REQ_TICK, 16'hFFFF);
        send_item(REQ_TICK, '0);

        repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
                send_item(REQ_TICK, PERIOD_W'($urandom));
            end else if (pick < 92) begin
                send_item(REQ_CREATE, PERIOD_W'($urandom));
            end else if (pick < 96) begin
                send_item(REQ_CREATE, PERIOD_W'(BASE_PERIOD_MS * $urandom_range(1, 6553)));
            end else begin
                send_item(REQ_CREATE, PERIOD_W'($urandom_range(0, 3 * BASE_PERIOD_MS)));
            end
        end
        s_tvalid <= 1'b0;

        repeat (2) @(posedge aclk);
        while (pending_results != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d transactions (%0d creates, %0d ticks) over four idle patterns.",
                 items_sent, creates_sent, items_sent - creates_sent);
        $display("Checked %0d results; widest ready burst was %0d windows.",
                 results_checked, widest_burst);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
